// ===== rtl/pfo_pkg.sv =====
// Shared types and constants for the polyphase FIR oversampler.
`timescale 1ns / 1ps

package pfo_pkg;

  localparam int DATA_W         = 32;
  localparam int ACC_W          = 2 * DATA_W;
  localparam int FUNC_W         = 2;
  localparam int PHASE_IN_W     = 3;
  localparam int TAP_IN_W       = 5;
  localparam int CFG_W          = 2;
  localparam int MAX_FACTOR_DEF = 8;
  localparam int TAPS_DEF       = 32;

  // input word layout, lowest bit first
  localparam int SAMPLE_LSB = 0;
  localparam int PHASE_LSB  = SAMPLE_LSB + DATA_W;
  localparam int TAP_LSB    = PHASE_LSB + PHASE_IN_W;
  localparam int COEF_LSB   = TAP_LSB + TAP_IN_W;
  localparam int IN_BITS    = COEF_LSB + DATA_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] FACTOR_LOG2_RST = 2'd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_INTERP = 2'd1,
    FUNC_DECI   = 2'd2,
    FUNC_FLUSH  = 2'd3
  } func_t;

  typedef struct packed {
    logic load_coef;
    logic push_interp;
    logic push_deci;
    logic new_group;
    logic fir_start;
    logic issue;
    logic emit;
    logic emit_last;
    logic deci_accum;
    logic flush;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/polyphase_fir_oversampler_unit.sv =====
// Top level of the polyphase FIR oversampler: stream ports, config register, control and datapath.
`timescale 1ns / 1ps

// Usage
//   in_*  : one word per command; in_tuser selects load coefficient, interpolate,
//           decimate or flush. Loads land in the coefficient bank at phase, tap.
//   out_* : interpolate gives one word per phase, tlast on the final phase;
//           decimate gives one word (tlast set) after the last phase of a group.
//   cfg_* : factor_log2, written while the block is idle; factor = 1 << factor_log2
//           with 0 read as 1, capped at MAX_FACTOR.
// Operation
//   One shared 32x32 MAC walks the taps, one tap per cycle; a phase runs start,
//   tap reads, pipe drain, then emit or (mid decimation group) an add. Interpolate
//   runs every phase of the factor, decimate one phase per word. One item at a time.
// Reset and stall
//   After reset, and after each flush, a clearing pass zeroes the histories of
//   every phase and tap with in_tready low.
//   Results wait in an output register; a stalled receiver holds the MAC loop at
//   the end of a phase until the register frees, and nothing is dropped.
module polyphase_fir_oversampler_unit #(
  parameter int MAX_FACTOR = pfo_pkg::MAX_FACTOR_DEF,
  parameter int TAPS       = pfo_pkg::TAPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pfo_pkg::CFG_W-1:0]         cfg_wr_data,   // factor_log2
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample_in[31:0], coef_phase[34:32], coef_tap[39:35], coef_value[71:40]
  input  logic [pfo_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [pfo_pkg::FUNC_W-1:0]        in_tuser,      // func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pfo_pkg::DATA_W-1:0]        out_tdata,     // sample_out
  output logic                              out_tlast      // last
);

  localparam int PW = $clog2(MAX_FACTOR);
  localparam int TW = $clog2(TAPS);

  pfo_pkg::cmd_t  cmd;
  pfo_pkg::stat_t stat;
  logic [PW-1:0]  phase;
  logic [TW-1:0]  tap;

  pfo_ctrl #(
    .MAX_FACTOR (MAX_FACTOR),
    .TAPS       (TAPS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_func     (pfo_pkg::func_t'(in_tuser)),
    .cmd         (cmd),
    .phase       (phase),
    .tap         (tap),
    .stat        (stat)
  );

  pfo_datapath #(
    .MAX_FACTOR (MAX_FACTOR),
    .TAPS       (TAPS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .phase         (phase),
    .tap           (tap),
    .stat          (stat),
    .in_sample     (in_tdata[pfo_pkg::SAMPLE_LSB +: pfo_pkg::DATA_W]),
    .in_coef_phase (in_tdata[pfo_pkg::PHASE_LSB +: pfo_pkg::PHASE_IN_W]),
    .in_coef_tap   (in_tdata[pfo_pkg::TAP_LSB +: pfo_pkg::TAP_IN_W]),
    .in_coef_value (in_tdata[pfo_pkg::COEF_LSB +: pfo_pkg::DATA_W]),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast)
  );

endmodule

// ===== rtl/pfo_ctrl.sv =====
// Sequencer for the oversampler: clearing sweep, tap loop, phase loop and handshakes.
`timescale 1ns / 1ps

module pfo_ctrl #(
  parameter int MAX_FACTOR = pfo_pkg::MAX_FACTOR_DEF,
  parameter int TAPS       = pfo_pkg::TAPS_DEF,
  localparam int PW        = $clog2(MAX_FACTOR),
  localparam int TW        = $clog2(TAPS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [pfo_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  pfo_pkg::func_t           in_func,
  output pfo_pkg::cmd_t            cmd,
  output logic [PW-1:0]            phase,
  output logic [TW-1:0]            tap,
  input  pfo_pkg::stat_t           stat
);

  localparam int FW = $clog2(MAX_FACTOR + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_START = 6'b000100,
    S_MAC   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [PW-1:0]              cur_phase_r, cur_phase_nxt;
  logic [PW-1:0]              deci_phase_r, deci_phase_nxt;
  logic [TW-1:0]              tap_r, tap_nxt;
  logic                       deci_mode_r, deci_mode_nxt;
  logic [pfo_pkg::CFG_W-1:0]  factor_log2_r;

  logic [1:0]    lg;
  logic [3:0]    pow;
  logic [FW-1:0] factor;
  logic [PW-1:0] eff_phase;
  logic          cur_last;
  logic          tap_last;
  logic          sweep_last;

  always_comb begin
    lg     = (factor_log2_r == 2'd0) ? 2'd1 : factor_log2_r;
    pow    = 4'd1 << lg;
    factor = (32'(pow) > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(pow);
  end

  // drop a partial group that the current factor no longer reaches
  assign eff_phase  = (FW'(deci_phase_r) >= factor) ? '0 : deci_phase_r;
  assign cur_last   = (FW'(cur_phase_r) + FW'(1)) == factor;
  assign tap_last   = tap_r == TW'(TAPS - 1);
  assign sweep_last = tap_last && (cur_phase_r == PW'(MAX_FACTOR - 1));
  assign tap        = tap_r;

  always_comb begin
    state_nxt      = state_r;
    cur_phase_nxt  = cur_phase_r;
    deci_phase_nxt = deci_phase_r;
    tap_nxt        = tap_r;
    deci_mode_nxt  = deci_mode_r;
    cmd            = '0;
    phase          = cur_phase_r;
    in_tready      = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sweep_last) begin
          tap_nxt       = '0;
          cur_phase_nxt = '0;
          state_nxt     = S_IDLE;
        end else if (tap_last) begin
          tap_nxt       = '0;
          cur_phase_nxt = cur_phase_r + PW'(1);
        end else begin
          tap_nxt = tap_r + TW'(1);
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        phase     = eff_phase;
        if (in_tvalid) begin
          case (in_func)
            pfo_pkg::FUNC_LOAD: begin
              cmd.load_coef = 1'b1;
            end
            pfo_pkg::FUNC_INTERP: begin
              cmd.push_interp = 1'b1;
              deci_mode_nxt   = 1'b0;
              cur_phase_nxt   = '0;
              state_nxt       = S_START;
            end
            pfo_pkg::FUNC_DECI: begin
              cmd.push_deci  = 1'b1;
              cmd.new_group  = eff_phase == '0;
              deci_mode_nxt  = 1'b1;
              cur_phase_nxt  = eff_phase;
              deci_phase_nxt = eff_phase;
              state_nxt      = S_START;
            end
            pfo_pkg::FUNC_FLUSH: begin
              cmd.flush      = 1'b1;
              deci_phase_nxt = '0;
              cur_phase_nxt  = '0;
              tap_nxt        = '0;
              state_nxt      = S_CLEAR;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_START: begin
        cmd.fir_start = 1'b1;
        tap_nxt       = '0;
        state_nxt     = S_MAC;
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        if (tap_last) begin
          tap_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          tap_nxt = tap_r + TW'(1);
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!deci_mode_r) begin
          if (stat.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = cur_last;
            if (cur_last) begin
              state_nxt = S_IDLE;
            end else begin
              cur_phase_nxt = cur_phase_r + PW'(1);
              state_nxt     = S_START;
            end
          end
        end else if (cur_last) begin
          if (stat.out_free) begin
            cmd.emit       = 1'b1;
            cmd.emit_last  = 1'b1;
            deci_phase_nxt = '0;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.deci_accum = 1'b1;
          deci_phase_nxt = cur_phase_r + PW'(1);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      cur_phase_r   <= '0;
      deci_phase_r  <= '0;
      tap_r         <= '0;
      deci_mode_r   <= 1'b0;
      factor_log2_r <= pfo_pkg::FACTOR_LOG2_RST;
    end else begin
      state_r      <= state_nxt;
      cur_phase_r  <= cur_phase_nxt;
      deci_phase_r <= deci_phase_nxt;
      tap_r        <= tap_nxt;
      deci_mode_r  <= deci_mode_nxt;
      if (cfg_wr_en) begin
        factor_log2_r <= cfg_wr_data;
      end
    end
  end

`ifndef ASSERT_OFF
  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result loaded while output register still full");

  a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> !stat.pipe_busy)
    else $error("result taken before the MAC pipeline drained");

  a_tap_loop_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC && tap_last) |=> state_r == S_DRAIN)
    else $error("tap loop did not end after the last tap");

  a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> FW'(cur_phase_r) < factor)
    else $error("phase beyond the oversampling factor");
`endif

endmodule

// ===== rtl/pfo_datapath.sv =====
// Coefficient and history memories, pipelined MAC, decimation sum and output register.
`timescale 1ns / 1ps

module pfo_datapath #(
  parameter int MAX_FACTOR = pfo_pkg::MAX_FACTOR_DEF,
  parameter int TAPS       = pfo_pkg::TAPS_DEF,
  localparam int PW        = $clog2(MAX_FACTOR),
  localparam int TW        = $clog2(TAPS)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pfo_pkg::cmd_t                       cmd,
  input  logic [PW-1:0]                       phase,
  input  logic [TW-1:0]                       tap,
  output pfo_pkg::stat_t                      stat,
  input  logic [pfo_pkg::DATA_W-1:0]          in_sample,
  input  logic [pfo_pkg::PHASE_IN_W-1:0]      in_coef_phase,
  input  logic [pfo_pkg::TAP_IN_W-1:0]        in_coef_tap,
  input  logic [pfo_pkg::DATA_W-1:0]          in_coef_value,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pfo_pkg::DATA_W-1:0]          out_tdata,
  output logic                                out_tlast
);

  localparam int DEPTH = MAX_FACTOR * TAPS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = pfo_pkg::DATA_W;
  localparam int AccW  = pfo_pkg::ACC_W;

  logic [DW-1:0] coef_mem   [DEPTH];
  logic [DW-1:0] interp_mem [TAPS];
  logic [DW-1:0] deci_mem   [DEPTH];

  logic [TW-1:0]          interp_pos_r;
  logic [TW-1:0]          deci_pos_r;
  logic [TW-1:0]          slot_r;
  logic                   mode_r;
  logic [DW-1:0]          deci_sum_r;
  logic signed [DW-1:0]   coef_rd_r;
  logic signed [DW-1:0]   ihist_rd_r;
  logic signed [DW-1:0]   dhist_rd_r;
  logic                   v1_r;
  logic                   v2_r;
  logic signed [AccW-1:0] prod_r;
  logic [AccW-1:0]        acc_r;
  logic                   out_valid_r;
  logic [DW-1:0]          out_data_r;
  logic                   out_last_r;

  logic [TW-1:0]        interp_inc;
  logic [TW-1:0]        deci_wpos;
  logic [TW-1:0]        slot_dec;
  logic [AW-1:0]        phase_base;
  logic                 load_ok;
  logic [AW-1:0]        load_addr;
  logic [AW-1:0]        coef_raddr;
  logic [AW-1:0]        deci_waddr;
  logic [AW-1:0]        deci_raddr;
  logic [DW-1:0]        deci_wdata;
  logic [TW-1:0]        interp_waddr;
  logic [DW-1:0]        interp_wdata;
  logic signed [DW-1:0] hist_sel;
  logic [DW-1:0]        acc_hi;

  function automatic logic [TW-1:0] ptr_inc(input logic [TW-1:0] p);
    return (p == TW'(TAPS - 1)) ? '0 : p + TW'(1);
  endfunction

  assign interp_inc = ptr_inc(interp_pos_r);
  assign deci_wpos  = cmd.new_group ? ptr_inc(deci_pos_r) : deci_pos_r;
  // walk the ring from newest to oldest
  assign slot_dec   = (slot_r == '0) ? TW'(TAPS - 1) : slot_r - TW'(1);
  assign phase_base = AW'(phase) * AW'(TAPS);

  assign load_ok    = (32'(in_coef_phase) < MAX_FACTOR) && (32'(in_coef_tap) < TAPS);
  assign load_addr  = AW'(in_coef_phase) * AW'(TAPS) + AW'(in_coef_tap);
  assign coef_raddr = phase_base + AW'(tap);

  assign deci_waddr   = cmd.clear ? phase_base + AW'(tap) : phase_base + AW'(deci_wpos);
  assign deci_wdata   = cmd.clear ? '0 : in_sample;
  assign deci_raddr   = phase_base + AW'(slot_r);
  assign interp_waddr = cmd.clear ? tap : interp_inc;
  assign interp_wdata = cmd.clear ? '0 : in_sample;

  assign hist_sel = mode_r ? dhist_rd_r : ihist_rd_r;
  assign acc_hi   = acc_r[AccW-1:DW];

  always_ff @(posedge clk) begin
    if (cmd.load_coef && load_ok) begin
      coef_mem[load_addr] <= in_coef_value;
    end
    coef_rd_r <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear || cmd.push_interp) begin
      interp_mem[interp_waddr] <= interp_wdata;
    end
    ihist_rd_r <= interp_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear || cmd.push_deci) begin
      deci_mem[deci_waddr] <= deci_wdata;
    end
    dhist_rd_r <= deci_mem[deci_raddr];
  end

  // product and accumulator carry no reset
  always_ff @(posedge clk) begin
    prod_r <= coef_rd_r * hist_sel;
    if (cmd.fir_start) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.emit) begin
      out_data_r <= mode_r ? deci_sum_r + acc_hi : acc_hi;
      out_last_r <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interp_pos_r <= '0;
      deci_pos_r   <= '0;
      slot_r       <= '0;
      mode_r       <= 1'b0;
      deci_sum_r   <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.flush) begin
        interp_pos_r <= '0;
        deci_pos_r   <= '0;
        deci_sum_r   <= '0;
      end
      if (cmd.push_interp) begin
        interp_pos_r <= interp_inc;
        mode_r       <= 1'b0;
      end
      if (cmd.push_deci) begin
        deci_pos_r <= deci_wpos;
        mode_r     <= 1'b1;
        if (cmd.new_group) begin
          deci_sum_r <= '0;
        end
      end
      if (cmd.fir_start) begin
        slot_r <= mode_r ? deci_pos_r : interp_pos_r;
      end else if (cmd.issue) begin
        slot_r <= slot_dec;
      end
      if (cmd.deci_accum) begin
        deci_sum_r <= deci_sum_r + acc_hi;
      end else if (cmd.emit && mode_r) begin
        deci_sum_r <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.pipe_busy = v1_r | v2_r;
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== bench/tb_polyphase_fir_oversampler_unit.sv =====
// Self-checking bench for the polyphase FIR oversampler: directed rows, random words, predictor.
`timescale 1ns / 1ps

module tb_polyphase_fir_oversampler_unit;

  localparam int MAX_F         = pfo_pkg::MAX_FACTOR_DEF;
  localparam int TAPS          = pfo_pkg::TAPS_DEF;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = MAX_F * (TAPS + 6) + 64;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 1000000;
  // the reset factor of 2x reads phases 0 and 1 only
  localparam int RESET_PHASES  = 2;

  typedef struct {
    pfo_pkg::func_t func;
    logic [31:0]    sample;
    logic [2:0]     phase;
    logic [4:0]     tap;
    logic [31:0]    coef;
    bit             typed;
    logic [31:0]    want;
  } word_t;

  typedef struct {
    logic [pfo_pkg::DATA_W-1:0] value;
    logic                       mark;
  } owed_t;

  logic                          clk;
  logic                          rst_n       = 1'b0;
  logic                          cfg_wr_en   = 1'b0;
  logic [pfo_pkg::CFG_W-1:0]     cfg_wr_data = '0;
  logic                          in_tvalid   = 1'b0;
  logic                          in_tready;
  logic [pfo_pkg::IN_DATA_W-1:0] in_tdata    = '0;
  logic [pfo_pkg::FUNC_W-1:0]    in_tuser    = pfo_pkg::FUNC_LOAD;
  logic                          out_tvalid;
  logic                          out_tready  = 1'b0;
  logic [pfo_pkg::DATA_W-1:0]    out_tdata;
  logic                          out_tlast;

  // predictor state
  logic [31:0] coef_bank  [MAX_F*TAPS];
  logic [31:0] interp_ring[TAPS];
  logic [31:0] deci_ring  [MAX_F*TAPS];
  int          interp_head;
  int          deci_head;
  int          deci_slot;
  logic [31:0] deci_acc;
  logic [1:0]  fac_log2;

  owed_t owed_samples[$];
  word_t rows[$];
  int    errors        = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    hold_left     = 0;
  bit    hold_req      = 1'b0;
  bit    offering      = 1'b0;
  int    cycle_count;

  polyphase_fir_oversampler_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int active_factor();
    int lg;
    int f;
    lg = (fac_log2 == 2'd0) ? 1 : int'(fac_log2);
    f = 1 << lg;
    return (f > MAX_F) ? MAX_F : f;
  endfunction

  // Dot product of one phase's taps with a ring, newest sample first.
  function automatic logic [31:0] phase_dot(input bit deci, input int head, input int ph);
    logic [63:0]        acc;
    logic signed [63:0] x;
    logic signed [63:0] h;
    int                 i;
    int                 slot;
    acc = '0;
    for (i = 0; i < TAPS; i++) begin
      slot = (head + TAPS - i) % TAPS;
      x = deci ? $signed(deci_ring[ph*TAPS+slot]) : $signed(interp_ring[slot]);
      h = $signed(coef_bank[ph*TAPS+i]);
      acc = acc + x * h;
    end
    return acc[63:32];
  endfunction

  task automatic clear_histories();
    int i;
    for (i = 0; i < TAPS; i++) interp_ring[i] = '0;
    for (i = 0; i < MAX_F*TAPS; i++) deci_ring[i] = '0;
    interp_head = 0;
    deci_head = 0;
    deci_slot = 0;
    deci_acc = '0;
  endtask

  task automatic owe(input logic [31:0] v, input logic m);
    owed_t e;
    e.value = v;
    e.mark = m;
    owed_samples.push_back(e);
  endtask

  // Advance the predictor by one accepted word and queue the samples it owes.
  task automatic predict_outputs(input word_t w);
    int fac;
    int p;
    fac = active_factor();
    case (w.func)
      pfo_pkg::FUNC_LOAD: begin
        coef_bank[int'(w.phase)*TAPS + int'(w.tap)] = w.coef;
      end
      pfo_pkg::FUNC_INTERP: begin
        interp_head = (interp_head + 1) % TAPS;
        interp_ring[interp_head] = w.sample;
        for (p = 0; p < fac; p++)
          owe(w.typed ? w.want : phase_dot(1'b0, interp_head, p), p == fac - 1);
      end
      pfo_pkg::FUNC_DECI: begin
        // a group left over from a larger factor is dropped
        if (deci_slot >= fac) deci_slot = 0;
        if (deci_slot == 0) begin
          deci_head = (deci_head + 1) % TAPS;
          deci_acc = '0;
        end
        deci_ring[deci_slot*TAPS + deci_head] = w.sample;
        deci_acc = deci_acc + phase_dot(1'b1, deci_head, deci_slot);
        if (deci_slot + 1 == fac) begin
          owe(w.typed ? w.want : deci_acc, 1'b1);
          deci_slot = 0;
          deci_acc = '0;
        end else begin
          deci_slot++;
        end
      end
      default: clear_histories();
    endcase
  endtask

  function automatic word_t word_of(input pfo_pkg::func_t f, input logic [31:0] s,
                                    input int ph, input int tp, input logic [31:0] c,
                                    input bit typed = 1'b0, input logic [31:0] want = '0);
    word_t w;
    w.func = f;
    w.sample = s;
    w.phase = ph[2:0];
    w.tap = tp[4:0];
    w.coef = c;
    w.typed = typed;
    w.want = want;
    return w;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input word_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w.coef, w.tap, w.phase, w.sample};
    in_tuser  <= w.func;
    offering = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_outputs(w);
  endtask

  // Drop valid, then hold until every owed sample has arrived.
  task automatic wait_drain();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
    while (owed_samples.size() != 0) @(posedge clk);
  endtask

  task automatic set_factor(input logic [1:0] v);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fac_log2 = v;
  endtask

  task automatic fill_bank(input bit random_coefs, input int phases);
    int ph;
    int tp;
    for (ph = 0; ph < phases; ph++)
      for (tp = 0; tp < TAPS; tp++)
        send_word(word_of(pfo_pkg::FUNC_LOAD, $urandom, ph, tp,
                          random_coefs ? $urandom : 32'h0));
  endtask

  task automatic run_random(input int count);
    int sent;
    int pick;
    int k;
    int fac;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      fac = active_factor();
      if (pick < 40) begin
        send_word(word_of(pfo_pkg::FUNC_INTERP, rand_sample(), $urandom_range(7),
                          $urandom_range(31), $urandom));
        sent++;
      end else if (pick < 75) begin
        // full decimation group with random content
        for (k = 0; k < fac; k++)
          send_word(word_of(pfo_pkg::FUNC_DECI, rand_sample(), $urandom_range(7),
                            $urandom_range(31), $urandom));
        sent += fac;
      end else if (pick < 87) begin
        send_word(word_of(pfo_pkg::FUNC_LOAD, $urandom, $urandom_range(7),
                          $urandom_range(31), rand_sample()));
        sent++;
      end else if (pick < 95) begin
        send_word(word_of(pfo_pkg::FUNC_DECI, rand_sample(), $urandom_range(7),
                          $urandom_range(31), $urandom));
        sent++;
      end else begin
        send_word(word_of(pfo_pkg::FUNC_FLUSH, $urandom, $urandom_range(7),
                          $urandom_range(31), $urandom));
        sent++;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, want %h at %0t ns", what, got, want, $realtime);
    errors++;
  endtask

  task automatic take_result(input logic [31:0] data, input logic mark);
    owed_t e;
    if (owed_samples.size() == 0) begin
      report_mismatch("unexpected word", data, '0);
    end else begin
      e = owed_samples.pop_front();
      if (data !== e.value) report_mismatch("sample_out", data, e.value);
      if (mark !== e.mark) report_mismatch("last", {31'd0, mark}, {31'd0, e.mark});
    end
  endtask

  // Receiver: check on handshake, then pick the next ready level.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) take_result(out_tdata, out_tlast);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("polyphase_fir_oversampler_unit regression: fail");
    $finish;
  end

  initial begin
    int i;
    for (i = 0; i < MAX_F*TAPS; i++) coef_bank[i] = '0;
    clear_histories();
    fac_log2 = pfo_pkg::FACTOR_LOG2_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 37;
    recv_idle_pct = 84;
    fill_bank(1'b0, RESET_PHASES);

    // all-zero bank: every output is zero
    rows.push_back(word_of(pfo_pkg::FUNC_INTERP, 32'h1234_5678, 0, 0, 32'h0, 1'b1, 32'h0));
    rows.push_back(word_of(pfo_pkg::FUNC_DECI, 32'h7FFF_FFFF, 0, 0, 32'h0));
    rows.push_back(word_of(pfo_pkg::FUNC_DECI, 32'h8000_0000, 0, 0, 32'h0, 1'b1, 32'h0));
    // most negative tap 0 on both phases: extremes square and cross
    rows.push_back(word_of(pfo_pkg::FUNC_LOAD, 32'h0, 0, 0, 32'h8000_0000));
    rows.push_back(word_of(pfo_pkg::FUNC_LOAD, 32'h0, 1, 0, 32'h8000_0000));
    rows.push_back(word_of(pfo_pkg::FUNC_INTERP, 32'h8000_0000, 0, 0, 32'h0,
                           1'b1, 32'h4000_0000));
    rows.push_back(word_of(pfo_pkg::FUNC_INTERP, 32'h7FFF_FFFF, 0, 0, 32'h0,
                           1'b1, 32'hC000_0000));
    rows.push_back(word_of(pfo_pkg::FUNC_LOAD, 32'h0, 7, 31, 32'h7FFF_FFFF));
    rows.push_back(word_of(pfo_pkg::FUNC_LOAD, 32'h0, 1, 31, 32'h7FFF_FFFF));
    rows.push_back(word_of(pfo_pkg::FUNC_DECI, 32'h8000_0000, 0, 0, 32'h0));
    rows.push_back(word_of(pfo_pkg::FUNC_DECI, 32'h7FFF_FFFF, 0, 0, 32'h0));
    rows.push_back(word_of(pfo_pkg::FUNC_FLUSH, 32'hFFFF_FFFF, 7, 31, 32'hFFFF_FFFF));
    rows.push_back(word_of(pfo_pkg::FUNC_INTERP, 32'h0, 0, 0, 32'h0, 1'b1, 32'h0));
    rows.push_back(word_of(pfo_pkg::FUNC_DECI, 32'h7FFF_FFFF, 0, 0, 32'h0));
    // flush in the middle of a group drops it
    rows.push_back(word_of(pfo_pkg::FUNC_FLUSH, 32'h0, 0, 0, 32'h0));
    rows.push_back(word_of(pfo_pkg::FUNC_DECI, 32'h0000_0001, 0, 0, 32'h0));
    rows.push_back(word_of(pfo_pkg::FUNC_DECI, 32'hFFFF_FFFF, 0, 0, 32'h0));
    rows.push_back(word_of(pfo_pkg::FUNC_LOAD, 32'h0, 0, 17, 32'h0000_0001));
    rows.push_back(word_of(pfo_pkg::FUNC_INTERP, 32'h5A5A_5A5A, 0, 0, 32'h0));
    rows.push_back(word_of(pfo_pkg::FUNC_INTERP, 32'hA5A5_A5A5, 0, 0, 32'h0));
    foreach (rows[i]) send_word(rows[i]);

    set_factor(2'd3);
    fill_bank(1'b1, MAX_F);

    // starve the output while words keep coming, then pause for a full drain
    send_idle_pct = 0;
    hold_req = 1'b1;
    repeat (5) send_word(word_of(pfo_pkg::FUNC_INTERP, rand_sample(), 0, 0, 32'h0));
    wait_drain();
    send_idle_pct = 37;
    run_random(75);

    // shrink the factor with a partial group pending
    wait_drain();
    send_word(word_of(pfo_pkg::FUNC_FLUSH, 32'h0, 0, 0, 32'h0));
    repeat (3) send_word(word_of(pfo_pkg::FUNC_DECI, rand_sample(), 0, 0, 32'h0));
    set_factor(2'd1);
    repeat (2) send_word(word_of(pfo_pkg::FUNC_DECI, rand_sample(), 0, 0, 32'h0));

    set_factor(2'd0);
    send_idle_pct = 84;
    recv_idle_pct = 37;
    run_random(75);

    set_factor(2'd2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(70);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_samples.size() != 0) report_mismatch("words never seen", owed_samples.size(), 0);
    if (errors == 0) begin
      $display("polyphase_fir_oversampler_unit regression: pass");
    end else begin
      $display("polyphase_fir_oversampler_unit regression: fail");
    end
    $finish;
  end

endmodule
